### design/smo_pkg.sv
// Shared types, sizes and codes for the square marker overlay.
// Used by every module of the block; depends on nothing else.
package smo_pkg;

    localparam int MAX_POINTS = 16;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam int POINT_W = 13;
    localparam int PIXEL_W = 12;
    localparam int SIZE_W = 6;
    localparam int HALF_W = SIZE_W - 1;
    localparam int DIFF_W = POINT_W + 2;
    localparam int CH_W = 8;

    localparam int OP_W = 2;
    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MARKER_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_CHANNEL = 3'd4;

    typedef struct packed {
        logic [SIZE_W-1:0] marker_size;
        logic [CH_W-1:0]   color_red;
        logic [CH_W-1:0]   color_green;
        logic [CH_W-1:0]   color_blue;
        logic              three_channel;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic clear;
    } tbl_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             overflow;
    } tbl_status_t;

endpackage

### design/smo_point_table.sv
// Marker point table with load and clear, the sticky drop flag and the
// parallel window compare of one pixel against every stored point.
// Depends on smo_pkg.
module smo_point_table
    import smo_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tbl_cmd_t                  cmd,
    input  logic signed [POINT_W-1:0] point_x,
    input  logic signed [POINT_W-1:0] point_y,
    input  logic [PIXEL_W-1:0]        pixel_x,
    input  logic [PIXEL_W-1:0]        pixel_y,
    input  logic [HALF_W-1:0]         half,
    output logic                      hit,
    output tbl_status_t               status
);

    logic signed [POINT_W-1:0] col_reg [MAX_POINTS];
    logic signed [POINT_W-1:0] row_reg [MAX_POINTS];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      overflow_reg;
    logic                      overflow_next;
    logic                      full;
    logic                      store;
    logic [MAX_POINTS-1:0]     hit_vec;
    logic signed [DIFF_W-1:0]  px;
    logic signed [DIFF_W-1:0]  py;
    logic signed [DIFF_W-1:0]  hv;
    logic signed [DIFF_W-1:0]  dx [MAX_POINTS];
    logic signed [DIFF_W-1:0]  dy [MAX_POINTS];

    assign full = (count_reg == CNT_W'(MAX_POINTS));
    assign store = cmd.load && !full;

    always_comb
    begin
        count_next = count_reg;
        overflow_next = overflow_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            overflow_next = 1'b0;
        end
        else if (cmd.load)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            col_reg[count_reg[IDX_W-1:0]] <= point_x;
            row_reg[count_reg[IDX_W-1:0]] <= point_y;
        end
    end

    assign px = signed'({{(DIFF_W-PIXEL_W){1'b0}}, pixel_x});
    assign py = signed'({{(DIFF_W-PIXEL_W){1'b0}}, pixel_y});
    assign hv = signed'({{(DIFF_W-HALF_W){1'b0}}, half});

    always_comb
    begin
        for (int k = 0; k < MAX_POINTS; k++)
        begin
            dx[k] = px - DIFF_W'(col_reg[k]);
            dy[k] = py - DIFF_W'(row_reg[k]);
            hit_vec[k] = (CNT_W'(k) < count_reg)
                && (dx[k] >= -hv) && (dx[k] <= hv)
                && (dy[k] >= -hv) && (dy[k] <= hv);
        end
    end

    assign hit = |hit_vec;
    assign status.count = count_reg;
    assign status.overflow = overflow_reg;

endmodule

### design/smo_recolor.sv
// Channel selection for one pixel: marker color when covered, pass-through
// otherwise, with the mono mode rules. Depends on smo_pkg.
module smo_recolor
    import smo_pkg::*;
(
    input  cfg_t            cfg,
    input  logic            hit,
    input  logic [CH_W-1:0] in_ch0,
    input  logic [CH_W-1:0] in_ch1,
    input  logic [CH_W-1:0] in_ch2,
    output logic [CH_W-1:0] out_ch0,
    output logic [CH_W-1:0] out_ch1,
    output logic [CH_W-1:0] out_ch2
);

    always_comb
    begin
        if (cfg.three_channel)
        begin
            out_ch0 = hit ? cfg.color_blue : in_ch0;
            out_ch1 = hit ? cfg.color_green : in_ch1;
            out_ch2 = hit ? cfg.color_red : in_ch2;
        end
        else
        begin
            out_ch0 = hit ? cfg.color_red : in_ch0;
            out_ch1 = '0;
            out_ch2 = '0;
        end
    end

endmodule

### design/square_marker_overlay_top.sv
// Top level of the square marker overlay: input register, configuration
// registers, point table, recolor logic and result register.
// Depends on smo_pkg, smo_point_table and smo_recolor.
//
// Channel   Dir  Handshake          Contents
// s_axis    in   s_tvalid/s_tready  s_tuser: operation; s_tdata: point, pixel, channels
// m_axis    out  m_tvalid/m_tready  m_tdata: channels, marked, points_dropped
// cfg       in   cfg_we             cfg_index, cfg_wdata
//
// Each request is held in the input register, where a load or clear
// updates the table and a pixel is compared against all points in parallel.
// A pixel result goes from there to the result register and m_tdata; loads
// and clears produce none. One request per cycle is sustained unless a result stalls.
// Reset empties the table, clears the drop flag and loads register defaults.
// A stalled result holds only pixel requests behind it; the input register
// keeps accepting while it can drain.
module square_marker_overlay_top
    import smo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tuser: operation[1:0]
    input  logic [OP_W-1:0]       s_tuser,
    // tdata: point_x[12:0], point_y[25:13], pixel_x[37:26], pixel_y[49:38],
    // in_ch0[57:50], in_ch1[65:58], in_ch2[73:66], zero fill[79:74]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: out_ch0[7:0], out_ch1[15:8], out_ch2[23:16], marked[24],
    // points_dropped[25], zero fill[31:26]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t                  cfg_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [OP_W-1:0]       s1_op_reg;
    logic [IN_DATA_W-1:0]  s1_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  s_accept;
    logic                  s1_is_pixel;
    logic                  s1_advance;
    logic                  out_load;
    tbl_cmd_t              cmd;
    tbl_status_t           status;
    logic                  hit;
    logic [CH_W-1:0]       res_ch0;
    logic [CH_W-1:0]       res_ch1;
    logic [CH_W-1:0]       res_ch2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.marker_size <= SIZE_W'(1);
            cfg_reg.color_red <= 8'hFF;
            cfg_reg.color_green <= 8'h00;
            cfg_reg.color_blue <= 8'h00;
            cfg_reg.three_channel <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MARKER_SIZE:   cfg_reg.marker_size <= cfg_wdata[SIZE_W-1:0];
                REG_COLOR_RED:     cfg_reg.color_red <= cfg_wdata;
                REG_COLOR_GREEN:   cfg_reg.color_green <= cfg_wdata;
                REG_COLOR_BLUE:    cfg_reg.color_blue <= cfg_wdata;
                REG_THREE_CHANNEL: cfg_reg.three_channel <= cfg_wdata[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s1_is_pixel = s1_valid_reg && (s1_op_reg == OP_PIXEL);
    assign s1_advance = !(s1_is_pixel && out_valid_reg && !m_tready);
    assign s_tready = !s1_valid_reg || s1_advance;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = s1_is_pixel && s1_advance;

    assign cmd.load = s1_valid_reg && (s1_op_reg == OP_LOAD);
    assign cmd.clear = s1_valid_reg && (s1_op_reg == OP_CLEAR);

    always_comb
    begin
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_op_reg <= s_tuser;
            s1_data_reg <= s_tdata;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    smo_point_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .point_x (signed'(s1_data_reg[12:0])),
        .point_y (signed'(s1_data_reg[25:13])),
        .pixel_x (s1_data_reg[37:26]),
        .pixel_y (s1_data_reg[49:38]),
        .half    (cfg_reg.marker_size[SIZE_W-1:1]),
        .hit     (hit),
        .status  (status)
    );

    smo_recolor u_recolor (
        .cfg     (cfg_reg),
        .hit     (hit),
        .in_ch0  (s1_data_reg[57:50]),
        .in_ch1  (s1_data_reg[65:58]),
        .in_ch2  (s1_data_reg[73:66]),
        .out_ch0 (res_ch0),
        .out_ch1 (res_ch1),
        .out_ch2 (res_ch2)
    );

    assign out_data_next = {6'b0, status.overflow, hit, res_ch2, res_ch1, res_ch0};

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= CNT_W'(MAX_POINTS))
        else $error("Point count exceeds table capacity.");

    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && (status.count < CNT_W'(MAX_POINTS)))
            |=> (status.count == $past(status.count) + CNT_W'(1)))
        else $error("A load into a table with room did not store the point.");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> ((status.count == '0) && !status.overflow))
        else $error("A clear did not empty the table and the drop flag.");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && (status.count == CNT_W'(MAX_POINTS))) |=> status.overflow)
        else $error("A load into a full table did not set the drop flag.");
`endif

endmodule
